>>> hw/rtl/cglg_pkg.sv
// Shared types, register indexes and constants of the complex Gaussian generator.
`timescale 1ns / 1ps

package cglg_pkg;

    // Word widths.
    localparam int WORD_W   = 32;
    localparam int SAMPLE_W = 35;
    localparam int CFG_IDX_W = 3;
    localparam int S_TDATA_W = 8;
    localparam int M_TDATA_W = 72;

    // Six uniforms per sample, the first three form t1.
    localparam int UNIFORMS      = 6;
    localparam int HALF_UNIFORMS = 3;
    localparam int COUNT_W       = 3;

    // The constant 3.0 with 32 fraction bits.
    localparam logic [SAMPLE_W-1:0] THREE_FIX = SAMPLE_W'(3) << WORD_W;

    // Register reset values.
    localparam logic [WORD_W-1:0] RST_MULT_MAIN   = 32'd1664525;
    localparam logic [WORD_W-1:0] RST_INCR_MAIN   = 32'd1013904223;
    localparam logic [WORD_W-1:0] RST_MULT_SECOND = 32'd69069;
    localparam logic [WORD_W-1:0] RST_INCR_SECOND = 32'd3;
    localparam logic [WORD_W-1:0] RST_SEED        = 32'd0;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PORTABLE_MODE = 3'd0,
        CFG_MULT_MAIN     = 3'd1,
        CFG_INCR_MAIN     = 3'd2,
        CFG_MULT_SECOND   = 3'd3,
        CFG_INCR_SECOND   = 3'd4,
        CFG_SEED_MAIN     = 3'd5,
        CFG_SEED_SECOND   = 3'd6,
        CFG_SEED_SKIP     = 3'd7
    } cfg_index_t;

    // Controller states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_DONE
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic start;   // clear the sums, latch the last flag, take the first step
        logic step;    // take one generator step and add the previous uniform
        logic im_add;  // previous uniform belongs to t1
        logic finish;  // subtract the final uniform from both sums and load the output word
        logic settle;  // apply any pending skip bump
    } dp_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic out_free;  // output register can take a new word this cycle
    } dp_status_t;

endpackage

>>> hw/rtl/cglg_ctrl.sv
// Controller state machine that sequences the six generator steps of one sample.
`timescale 1ns / 1ps

module cglg_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  cglg_pkg::dp_status_t status,
    output cglg_pkg::dp_cmd_t    cmd
);
    import cglg_pkg::*;

    state_t               state_reg;
    state_t               state_next;
    logic [COUNT_W-1:0]   count_reg;
    logic [COUNT_W-1:0]   count_next;

    // State and step counter registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_RUN;
                    count_next = COUNT_W'(1);
                end
            end
            ST_RUN:
            begin
                if (count_reg == COUNT_W'(UNIFORMS - 1))
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    count_next = count_reg + COUNT_W'(1);
                end
            end
            ST_DONE:
            begin
                if (status.out_free)
                begin
                    if (in_valid)
                    begin
                        state_next = ST_RUN;
                        count_next = COUNT_W'(1);
                    end
                    else
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Outputs.
    always_comb
    begin
        cmd      = '0;
        in_ready = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready  = 1'b1;
                cmd.start = in_valid;
            end
            ST_RUN:
            begin
                cmd.step   = 1'b1;
                cmd.im_add = (count_reg <= COUNT_W'(HALF_UNIFORMS));
            end
            ST_DONE:
            begin
                if (status.out_free)
                begin
                    in_ready   = 1'b1;
                    cmd.finish = 1'b1;
                    cmd.start  = in_valid;
                    cmd.settle = !in_valid;
                end
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

endmodule

>>> hw/rtl/cglg_datapath.sv
// Datapath: configuration registers, the two generators, sample sums and output register.
`timescale 1ns / 1ps

module cglg_datapath (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_valid,
    input  logic [cglg_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [cglg_pkg::WORD_W-1:0]      cfg_data,
    input  logic                             in_last,
    input  cglg_pkg::dp_cmd_t                cmd,
    output cglg_pkg::dp_status_t             status,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic [cglg_pkg::SAMPLE_W-1:0]    out_real,
    output logic [cglg_pkg::SAMPLE_W-1:0]    out_imag,
    output logic                             out_last
);
    import cglg_pkg::*;

    // Configuration registers.
    logic                portable_reg;
    logic [WORD_W-1:0]   mult_main_reg;
    logic [WORD_W-1:0]   incr_main_reg;
    logic [WORD_W-1:0]   mult_second_reg;
    logic [WORD_W-1:0]   incr_second_reg;

    // Generator state. A skip bump found after a step is applied lazily.
    logic [WORD_W-1:0]   main_reg;
    logic [WORD_W-1:0]   second_reg;
    logic [WORD_W-1:0]   skip_reg;
    logic                pend_reg;

    // Sums and output word.
    logic [SAMPLE_W-1:0] re_acc_reg;
    logic [SAMPLE_W-1:0] im_acc_reg;
    logic                last_reg;
    logic                out_valid_reg;
    logic [SAMPLE_W-1:0] out_real_reg;
    logic [SAMPLE_W-1:0] out_imag_reg;
    logic                out_last_reg;

    logic                bump;
    logic [WORD_W-1:0]   bump_word;
    logic [WORD_W-1:0]   main_step;
    logic [WORD_W-1:0]   second_step;
    logic [WORD_W-1:0]   uniform;
    logic [SAMPLE_W-1:0] uniform_ext;
    logic                do_step;

    // A pending bump applies when the stepped second value met the skip marker.
    assign bump      = pend_reg && (second_reg == skip_reg);
    assign bump_word = {{(WORD_W-1){1'b0}}, bump};
    assign do_step   = cmd.start || cmd.step;

    // One LCG step each; the bump of the second value is folded in as an extra multiplier term.
    assign main_step   = mult_main_reg * main_reg + incr_main_reg;
    assign second_step = mult_second_reg * second_reg + incr_second_reg
                       + (bump ? mult_second_reg : '0);

    // Uniform from the values of the previous step.
    assign uniform     = portable_reg ? (main_reg - second_reg) : main_reg;
    assign uniform_ext = {{(SAMPLE_W-WORD_W){1'b0}}, uniform};

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            portable_reg    <= 1'b1;
            mult_main_reg   <= RST_MULT_MAIN;
            incr_main_reg   <= RST_INCR_MAIN;
            mult_second_reg <= RST_MULT_SECOND;
            incr_second_reg <= RST_INCR_SECOND;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index_t'(cfg_index))
                CFG_PORTABLE_MODE: portable_reg    <= cfg_data[0];
                CFG_MULT_MAIN:     mult_main_reg   <= cfg_data;
                CFG_INCR_MAIN:     incr_main_reg   <= cfg_data;
                CFG_MULT_SECOND:   mult_second_reg <= cfg_data;
                CFG_INCR_SECOND:   incr_second_reg <= cfg_data;
                CFG_SEED_MAIN,
                CFG_SEED_SECOND,
                CFG_SEED_SKIP:     ;
                default:           ;
            endcase
        end
    end

    // Generator state: seed writes, steps and the closing bump.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_reg   <= RST_SEED;
            second_reg <= RST_SEED;
            skip_reg   <= RST_SEED;
            pend_reg   <= 1'b0;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index_t'(cfg_index))
                CFG_SEED_MAIN:   main_reg   <= cfg_data;
                CFG_SEED_SECOND: second_reg <= cfg_data;
                CFG_SEED_SKIP:   skip_reg   <= cfg_data;
                CFG_PORTABLE_MODE,
                CFG_MULT_MAIN,
                CFG_INCR_MAIN,
                CFG_MULT_SECOND,
                CFG_INCR_SECOND: ;
                default:         ;
            endcase
        end
        else if (do_step)
        begin
            main_reg <= main_step;
            if (portable_reg)
            begin
                second_reg <= second_step;
                skip_reg   <= skip_reg + bump_word;
                pend_reg   <= 1'b1;
            end
        end
        else if (cmd.settle)
        begin
            second_reg <= second_reg + bump_word;
            skip_reg   <= skip_reg + bump_word;
            pend_reg   <= 1'b0;
        end
    end

    // Running sums: real starts at 3.0 and loses every uniform, imag adds t1 and subtracts t2.
    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            re_acc_reg <= THREE_FIX;
            im_acc_reg <= '0;
            last_reg   <= in_last;
        end
        else if (cmd.step)
        begin
            re_acc_reg <= re_acc_reg - uniform_ext;
            im_acc_reg <= cmd.im_add ? (im_acc_reg + uniform_ext) : (im_acc_reg - uniform_ext);
        end
    end

    // Output word, loaded with the last uniform folded in.
    always_ff @(posedge clk)
    begin
        if (cmd.finish)
        begin
            out_real_reg <= re_acc_reg - uniform_ext;
            out_imag_reg <= im_acc_reg - uniform_ext;
            out_last_reg <= last_reg;
        end
    end

    // Output valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.finish)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    assign status.out_free = !out_valid_reg || out_ready;
    assign out_valid       = out_valid_reg;
    assign out_real        = out_real_reg;
    assign out_imag        = out_imag_reg;
    assign out_last        = out_last_reg;

endmodule

>>> hw/rtl/complex_gaussian_lcg_generator.sv
// Top level of the complex Gaussian sample generator built from LCG uniforms.
//
// Each word taken on the s_ stream is a request; the block answers with one
// complex sample on the m_ stream. The sample is real = 3 - t1 - t2 and
// imag = t1 - t2, where t1 and t2 each sum three 32-bit uniforms; both parts
// are signed with 32 fraction bits. Uniforms come from one LCG (fast mode) or
// the difference of two LCGs with a skip marker (portable mode).
// A sample needs six dependent LCG steps, one 32x32 multiply-add per
// generator and cycle, so a new request is taken only once the current
// sample has been loaded into the output register.
// The configuration channel (cfg_valid, cfg_ready, cfg_index, cfg_data) is
// always ready; write it only while no request is in progress. Writing a seed
// register reloads its generator word at once.
// Reset restores the default register values and clears all seeds to zero.
// If the receiver stalls, one finished sample waits in the output register
// while the next one is computed; the block then stops taking requests.
`timescale 1ns / 1ps

module complex_gaussian_lcg_generator (
    input  logic                              clk,
    input  logic                              rst_n,
    // Request stream.
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [cglg_pkg::S_TDATA_W-1:0]    s_tdata,   // [0] end_of_vector, rest zero
    // Sample stream.
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [cglg_pkg::M_TDATA_W-1:0]    m_tdata,   // [34:0] real_part, [69:35] imag_part
    output logic                              m_tlast,
    // Configuration writes.
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [cglg_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [cglg_pkg::WORD_W-1:0]       cfg_data
);
    import cglg_pkg::*;

    dp_cmd_t             cmd;
    dp_status_t          status;
    logic [SAMPLE_W-1:0] out_real;
    logic [SAMPLE_W-1:0] out_imag;

    // Sequencer.
    cglg_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    // Generators and sums.
    cglg_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_last   (s_tdata[0]),
        .cmd       (cmd),
        .status    (status),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_real  (out_real),
        .out_imag  (out_imag),
        .out_last  (m_tlast)
    );

    // Pack the sample word, zero padded to whole bytes.
    assign m_tdata   = {{(M_TDATA_W - 2*SAMPLE_W){1'b0}}, out_imag, out_real};
    assign cfg_ready = 1'b1;

endmodule
